// ===== rtl/vmp_pkg.sv =====
// Shared types, field codes and field tables for the version message parser.
// No dependencies; imported by every module of the block.
package vmp_pkg;

    // Field index values (parser state, 4 bits)
    localparam logic [3:0] FLD_VERSION    = 4'd0;
    localparam logic [3:0] FLD_AGENT_LEN  = 4'd12;
    localparam logic [3:0] FLD_AGENT_BYTE = 4'd13;
    localparam logic [3:0] FLD_HEIGHT     = 4'd14;
    localparam logic [3:0] FLD_RELAY      = 4'd15;

    // Result codes (5 bits)
    localparam logic [4:0] CODE_AGENT_LEN  = 5'd12;
    localparam logic [4:0] CODE_AGENT_BYTE = 5'd13;
    localparam logic [4:0] CODE_RELAY      = 5'd15;
    localparam logic [4:0] CODE_END        = 5'd16;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TRUNC    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic [31:0] RELAY_MIN_VERSION = 32'd70001;
    localparam logic [7:0]  VARINT_TWO        = 8'hfd;
    localparam logic [7:0]  VARINT_FOUR       = 8'hfe;
    localparam logic [10:0] CAP_RESET         = 11'd257;

    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Up to three results per input item: field, default relay, end
    typedef struct packed {
        logic [2:0]    valid;
        t_result [2:0] slot;
    } t_push;

    function automatic logic [3:0] field_len(input logic [3:0] f);
        logic [3:0] len;
        case (f)
            4'd0, 4'd14:        len = 4'd4;
            4'd6, 4'd10:        len = 4'd2;
            4'd13, 4'd15:       len = 4'd1;
            FLD_AGENT_LEN:      len = 4'd0;
            default:            len = 4'd8;
        endcase
        return len;
    endfunction

    // Big-endian fields: address halves and ports
    function automatic logic field_be(input logic [3:0] f);
        logic be;
        case (f)
            4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10: be = 1'b1;
            default:                              be = 1'b0;
        endcase
        return be;
    endfunction

endpackage

// ===== rtl/vmp_parser.sv =====
// Byte-wise parse state and per-item result generation for the version parser.
// Depends on vmp_pkg; feeds vmp_result_fifo with up to three results per item.
module vmp_parser import vmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_eom,
    output t_push       o_push
);

    logic [10:0] r_cap;
    logic [3:0]  r_fi,  n_fi;
    logic [3:0]  r_bc,  n_bc;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_vw,  n_vw;
    logic [31:0] r_sv,  n_sv;
    logic [10:0] r_rem, n_rem;
    logic        r_drop, n_drop;
    logic        r_done, n_done;

    logic [63:0] acc_le;
    logic [63:0] acc_be;
    logic [3:0]  bc_inc;
    logic        needs_relay;
    t_push       push;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            acc_le[8*k +: 8] = (r_bc[2:0] == 3'(k)) ? (r_acc[8*k +: 8] | i_data_byte)
                                                     : r_acc[8*k +: 8];
        end
    end

    assign acc_be      = {r_acc[55:0], i_data_byte};
    assign bc_inc      = r_bc + 4'd1;
    assign needs_relay = !r_sv[31] && (r_sv >= RELAY_MIN_VERSION);

    always_comb begin
        logic        closed;
        logic        len_done;
        logic [63:0] len_val;
        logic [63:0] fld_val;
        logic [10:0] rem_dec;
        closed   = 1'b0;
        len_done = 1'b0;
        len_val  = '0;
        fld_val  = '0;
        rem_dec  = r_rem - 11'd1;
        n_fi   = r_fi;
        n_bc   = r_bc;
        n_acc  = r_acc;
        n_vw   = r_vw;
        n_sv   = r_sv;
        n_rem  = r_rem;
        n_drop = r_drop;
        n_done = r_done;
        push   = '0;

        if (r_drop) begin
            closed = 1'b1;
            if (i_eom) begin
                n_drop = 1'b0;
                n_fi = '0; n_bc = '0; n_acc = '0; n_vw = '0;
                n_sv = '0; n_rem = '0; n_done = 1'b0;
            end
        end else if (!r_done) begin
            case (r_fi)
                FLD_AGENT_LEN: begin
                    if (r_vw == 4'd0) begin
                        if (i_data_byte < VARINT_TWO) begin
                            len_val  = {56'd0, i_data_byte};
                            len_done = 1'b1;
                        end else begin
                            n_vw  = (i_data_byte == VARINT_TWO)  ? 4'd2 :
                                    (i_data_byte == VARINT_FOUR) ? 4'd4 : 4'd8;
                            n_acc = '0;
                            n_bc  = '0;
                        end
                    end else begin
                        n_acc = acc_le;
                        n_bc  = bc_inc;
                        if (bc_inc >= r_vw) begin
                            len_val  = acc_le;
                            len_done = 1'b1;
                        end
                    end
                    if (len_done) begin
                        push.valid[0] = 1'b1;
                        push.slot[0]  = '{code: CODE_AGENT_LEN, value: len_val,
                                          status: STATUS_OK, last: 1'b0};
                        n_acc = '0; n_bc = '0; n_vw = '0;
                        if (len_val >= {53'd0, r_cap}) begin
                            push.valid[2] = 1'b1;
                            push.slot[2]  = '{code: CODE_END, value: '0,
                                              status: STATUS_TOO_LONG, last: 1'b1};
                            n_fi = '0; n_sv = '0; n_rem = '0; n_done = 1'b0;
                            n_drop = !i_eom;
                            closed = 1'b1;
                        end else begin
                            n_rem = len_val[10:0];
                            n_fi  = (len_val[10:0] != 11'd0) ? FLD_AGENT_BYTE : FLD_HEIGHT;
                        end
                    end
                end
                FLD_AGENT_BYTE: begin
                    push.valid[0] = 1'b1;
                    push.slot[0]  = '{code: CODE_AGENT_BYTE, value: {56'd0, i_data_byte},
                                      status: STATUS_OK, last: 1'b0};
                    n_rem = rem_dec;
                    if (rem_dec == 11'd0) n_fi = FLD_HEIGHT;
                end
                FLD_RELAY: begin
                    push.valid[0] = 1'b1;
                    push.slot[0]  = '{code: CODE_RELAY, value: {56'd0, i_data_byte},
                                      status: STATUS_OK, last: 1'b0};
                    n_done = 1'b1;
                end
                default: begin
                    fld_val = field_be(r_fi) ? acc_be : acc_le;
                    n_acc   = fld_val;
                    n_bc    = bc_inc;
                    if (bc_inc >= field_len(r_fi)) begin
                        push.valid[0] = 1'b1;
                        push.slot[0]  = '{code: {1'b0, r_fi}, value: fld_val,
                                          status: STATUS_OK, last: 1'b0};
                        n_acc = '0;
                        n_bc  = '0;
                        if (r_fi == FLD_VERSION) n_sv = fld_val[31:0];
                        if (r_fi == FLD_HEIGHT) begin
                            if (needs_relay) n_fi = FLD_RELAY;
                            else             n_done = 1'b1;
                        end else begin
                            n_fi = r_fi + 4'd1;
                        end
                    end
                end
            endcase
        end

        if (i_eom && !closed) begin
            push.valid[2] = 1'b1;
            if (n_done) begin
                push.slot[2] = '{code: CODE_END, value: '0, status: STATUS_OK, last: 1'b1};
            end else if (n_fi == FLD_RELAY) begin
                // relay byte missing: report the default before closing
                push.valid[1] = 1'b1;
                push.slot[1]  = '{code: CODE_RELAY, value: 64'd1,
                                  status: STATUS_OK, last: 1'b0};
                push.slot[2]  = '{code: CODE_END, value: '0, status: STATUS_OK, last: 1'b1};
            end else begin
                push.slot[2] = '{code: CODE_END, value: '0, status: STATUS_TRUNC, last: 1'b1};
            end
            n_fi = '0; n_bc = '0; n_acc = '0; n_vw = '0;
            n_sv = '0; n_rem = '0; n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_fi   <= '0;
            r_bc   <= '0;
            r_acc  <= '0;
            r_vw   <= '0;
            r_sv   <= '0;
            r_rem  <= '0;
            r_drop <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (i_accept) begin
                r_fi   <= n_fi;
                r_bc   <= n_bc;
                r_acc  <= n_acc;
                r_vw   <= n_vw;
                r_sv   <= n_sv;
                r_rem  <= n_rem;
                r_drop <= n_drop;
                r_done <= n_done;
            end
        end
    end

    assign o_push.valid = i_accept ? push.valid : 3'b000;
    assign o_push.slot  = push.slot;

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_drop) |-> (o_push.valid == 3'b000))
        else $error("results produced while dropping");

    a_relay_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid[1] |-> o_push.valid[2])
        else $error("default relay without end result");

    a_too_long_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid[2] && o_push.slot[2].status == STATUS_TOO_LONG)
            |-> (!o_push.valid[1] && o_push.valid[0] && !n_done))
        else $error("too-long end without agent length");

endmodule

// ===== rtl/vmp_result_fifo.sv =====
// Result queue: takes up to three results per cycle, delivers one per ready cycle.
// Depends on vmp_pkg (t_result, t_push); DEPTH must be a power of two, at least 4.
module vmp_result_fifo import vmp_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   offs [3];
    logic [1:0]      n_pushes;
    logic            pop;

    assign offs[0]  = '0;
    assign offs[1]  = AW'(i_push.valid[0]);
    assign offs[2]  = AW'(i_push.valid[0]) + AW'(i_push.valid[1]);
    assign n_pushes = 2'(i_push.valid[0]) + 2'(i_push.valid[1]) + 2'(i_push.valid[2]);
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_push.valid[i]) r_mem[r_wptr + offs[i]] <= i_push.slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + AW'(n_pushes);
            r_rptr  <= r_rptr + AW'(pop);
            r_count <= r_count + CW'(n_pushes) - CW'(pop);
        end
    end

    // room for the worst-case item (three results)
    assign o_space = (r_count <= CW'(DEPTH - 3));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_pushes != 2'd0) |-> (int'(r_count) + int'(n_pushes) <= DEPTH + int'(pop)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("result count out of range");

    a_field_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_head.code != CODE_END)
            |-> (o_head.status == STATUS_OK && !o_head.last))
        else $error("field result with status or last set");

endmodule

// ===== rtl/version_message_parser_core.sv =====
// Version message body parser: one body byte per item in, decoded fields out.
// Results are registered in the result queue and offered on the master side from it.
// Throughput: one byte per cycle while the result queue has room for three results;
// results leave at one per cycle while m_axis_tready is high, so bytes closing a message
// with two or three results (default relay, agent too long) cost extra output cycles.
// Reset (synchronous, active low): parser restarts at version, capacity 257, queue empty.
module version_message_parser_core import vmp_pkg::*; #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,   // agent_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // [63:0] field_value
    output logic [6:0]  m_axis_tuser,    // [4:0] field_code, [6:5] status
    output logic        m_axis_tlast     // last_result
);

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = s_axis_tvalid && s_axis_tready;

    vmp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_data_byte   (s_axis_tdata),
        .i_eom         (s_axis_tlast),
        .o_push        (push)
    );

    vmp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = head.value;
    assign m_axis_tuser = {head.status, head.code};
    assign m_axis_tlast = head.last;

endmodule

// ===== test/tb_version_message_parser_core.sv =====
// Self-checking testbench for version_message_parser_core: streams version message bodies
// in, predicts every decoded field and end result, and compares them field by field.
// Depends on vmp_pkg and version_message_parser_core only.
`timescale 1ns / 100ps

module tb_version_message_parser_core;
    import vmp_pkg::*;

    localparam int         DRAIN_CYCLES  = 16;
    localparam int         LONG_STALL    = 200;
    localparam int         PHASE_BYTES   = 70;
    localparam int         NUM_PHASES    = 4;
    localparam logic [7:0] VARINT_EIGHT  = 8'hff;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } t_body_byte;

    typedef enum {
        MSG_FULL, MSG_TRAILING, MSG_RELAY_ABSENT, MSG_CUT,
        MSG_TOO_LONG, MSG_TOO_LONG_AT_MARK, MSG_NOISE
    } t_msg_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [10:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;      // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [63:0] field_value
    logic [6:0]  m_axis_tuser;           // [4:0] field_code, [6:5] status
    logic        m_axis_tlast;           // last_result

    version_message_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_body_byte  pending_bytes[$];
    t_result     expected_fields[$];
    int          errors = 0;
    int          results_seen = 0;
    int          msgs_sent = 0;
    int          body_bytes = 0;
    int          stall_asks = 0;
    logic [10:0] phase_cap = CAP_RESET;

    // parser state as the testbench sees it
    logic [10:0] cap_model;
    logic [3:0]  p_field;
    logic [3:0]  p_cnt;
    logic [63:0] p_acc;
    logic [3:0]  p_vw;
    logic [31:0] p_ver;
    logic [10:0] p_agent_left;
    bit          p_drop;
    bit          p_done;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("%0t: watchdog expired, %0d results still outstanding", $time,
                 expected_fields.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- prediction ----------------
    function automatic int bytes_in_field(input logic [3:0] f);
        case (f)
            FLD_VERSION, FLD_HEIGHT: return 4;
            4'd6, 4'd10:             return 2;
            default:                 return 8;
        endcase
    endfunction

    function automatic bit is_big_endian(input logic [3:0] f);
        return (f == 4'd4 || f == 4'd5 || f == 4'd6 || f == 4'd8 || f == 4'd9 || f == 4'd10);
    endfunction

    task automatic push_expect(input logic [4:0] code, input logic [63:0] val,
                               input logic [1:0] st, input logic last);
        t_result r;
        r.code = code;
        r.value = val;
        r.status = st;
        r.last = last;
        expected_fields.push_back(r);
    endtask

    task automatic restart_message();
        p_field = FLD_VERSION;
        p_cnt = '0;
        p_acc = '0;
        p_vw = '0;
        p_ver = '0;
        p_agent_left = '0;
        p_done = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic eom);
        logic [3:0]  f;
        logic [63:0] val;
        bit          done;
        if (p_drop) begin
            if (eom) begin
                p_drop = 1'b0;
                restart_message();
            end
            return;
        end
        if (!p_done) begin
            f = p_field;
            if (f == FLD_AGENT_LEN) begin
                done = 1'b0;
                val = '0;
                if (p_vw == 0) begin
                    if (b < VARINT_TWO) begin
                        val = {56'd0, b};
                        done = 1'b1;
                    end else begin
                        p_vw = (b == VARINT_TWO) ? 4'd2 : (b == VARINT_FOUR) ? 4'd4 : 4'd8;
                        p_acc = '0;
                        p_cnt = '0;
                    end
                end else begin
                    p_acc |= {56'd0, b} << (8 * p_cnt[2:0]);
                    p_cnt++;
                    if (p_cnt >= p_vw) begin
                        val = p_acc;
                        done = 1'b1;
                    end
                end
                if (done) begin
                    push_expect(CODE_AGENT_LEN, val, STATUS_OK, 1'b0);
                    p_acc = '0;
                    p_cnt = '0;
                    p_vw = '0;
                    if (val >= {53'd0, cap_model}) begin
                        push_expect(CODE_END, '0, STATUS_TOO_LONG, 1'b1);
                        restart_message();
                        p_drop = !eom;
                        return;
                    end
                    p_agent_left = val[10:0];
                    p_field = (p_agent_left != 0) ? FLD_AGENT_BYTE : FLD_HEIGHT;
                end
            end else if (f == FLD_AGENT_BYTE) begin
                push_expect(CODE_AGENT_BYTE, {56'd0, b}, STATUS_OK, 1'b0);
                p_agent_left--;
                if (p_agent_left == 0) p_field = FLD_HEIGHT;
            end else if (f == FLD_RELAY) begin
                push_expect(CODE_RELAY, {56'd0, b}, STATUS_OK, 1'b0);
                p_done = 1'b1;
            end else begin
                if (is_big_endian(f)) p_acc = {p_acc[55:0], b};
                else p_acc |= {56'd0, b} << (8 * p_cnt[2:0]);
                p_cnt++;
                if (p_cnt >= bytes_in_field(f)) begin
                    push_expect({1'b0, f}, p_acc, STATUS_OK, 1'b0);
                    if (f == FLD_VERSION) p_ver = p_acc[31:0];
                    p_acc = '0;
                    p_cnt = '0;
                    if (f == FLD_HEIGHT) begin
                        // relay only follows for non-negative versions from 70001 on
                        if (!p_ver[31] && p_ver >= RELAY_MIN_VERSION) p_field = FLD_RELAY;
                        else p_done = 1'b1;
                    end else begin
                        p_field = f + 4'd1;
                    end
                end
            end
        end
        if (eom) begin
            if (p_done) begin
                push_expect(CODE_END, '0, STATUS_OK, 1'b1);
            end else if (p_field == FLD_RELAY) begin
                push_expect(CODE_RELAY, 64'd1, STATUS_OK, 1'b0);
                push_expect(CODE_END, '0, STATUS_OK, 1'b1);
            end else begin
                push_expect(CODE_END, '0, STATUS_TRUNC, 1'b1);
            end
            restart_message();
        end
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic eom);
        t_body_byte it;
        it.data = d;
        it.eom = eom;
        pending_bytes.push_back(it);
        body_bytes++;
    endtask

    // varint with a randomly chosen (possibly oversized) prefix form
    task automatic encode_length(ref logic [7:0] body[$], input logic [63:0] alen);
        int form;
        int nbytes;
        forever begin
            form = $urandom_range(0, 3);
            if (form == 0 && alen < 64'(VARINT_TWO)) break;
            if (form == 1 && alen < 64'h1_0000) break;
            if (form == 2 && alen < 64'h1_0000_0000) break;
            if (form == 3) break;
        end
        case (form)
            0: begin body.push_back(alen[7:0]); nbytes = 0; end
            1: begin body.push_back(VARINT_TWO); nbytes = 2; end
            2: begin body.push_back(VARINT_FOUR); nbytes = 4; end
            default: begin body.push_back(VARINT_EIGHT); nbytes = 8; end
        endcase
        for (int i = 0; i < nbytes; i++) body.push_back(alen[8*i +: 8]);
    endtask

    task automatic queue_message(input t_msg_kind kind);
        logic [7:0]  body[$];
        logic [31:0] ver;
        logic [63:0] alen;
        bit          relay_needed;
        bit          reject;
        int          top;
        int          n_extra;
        if (kind == MSG_NOISE) begin
            n_extra = $urandom_range(1, 6);
            for (int i = 0; i < n_extra; i++) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (kind == MSG_RELAY_ABSENT) begin
                ver = $urandom_range(70001, 32'h7fff_ffff);
            end else begin
                case ($urandom_range(0, 6))
                    0: ver = RELAY_MIN_VERSION;
                    1: ver = RELAY_MIN_VERSION - 1;
                    2: ver = 32'h7fff_ffff;
                    3: ver = 32'h8000_0000 | $urandom;
                    4: ver = 32'hffff_ffff;
                    5: ver = $urandom;
                    default: ver = $urandom_range(0, 70001);
                endcase
            end
            relay_needed = !ver[31] && ver >= RELAY_MIN_VERSION;
            for (int i = 0; i < 4; i++) body.push_back(ver[8*i +: 8]);
            // services through nonce take 76 of these 82 random bytes
            for (int i = 0; i < 82; i++) body.push_back(8'($urandom_range(0, 255)));
            reject = (kind == MSG_TOO_LONG || kind == MSG_TOO_LONG_AT_MARK || phase_cap == 0);
            if (reject) begin
                case ($urandom_range(0, 4))
                    0: alen = {53'd0, phase_cap};
                    1: alen = {53'd0, phase_cap} + $urandom_range(0, 40);
                    2: alen = {32'd0, $urandom} | 64'h800;
                    3: alen = {$urandom, $urandom} | 64'h1_0000_0000;
                    default: alen = '1;
                endcase
                encode_length(body, alen);
                if (kind != MSG_TOO_LONG_AT_MARK) begin
                    n_extra = $urandom_range(1, 5);
                    for (int i = 0; i < n_extra; i++)
                        body.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                top = (phase_cap > 41) ? 40 : phase_cap - 1;
                alen = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, top));
                encode_length(body, alen);
                for (int i = 0; i < alen; i++) body.push_back(8'($urandom_range(0, 255)));
                for (int i = 0; i < 4; i++) body.push_back(8'($urandom_range(0, 255)));
                if (relay_needed && kind != MSG_RELAY_ABSENT)
                    body.push_back(8'($urandom_range(0, 255)));
                if (kind == MSG_TRAILING) n_extra = $urandom_range(1, 3);
                else if (kind == MSG_RELAY_ABSENT) n_extra = 0;
                else n_extra = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
                for (int i = 0; i < n_extra; i++) body.push_back(8'($urandom_range(0, 255)));
                if (kind == MSG_CUT) body = body[0 : $urandom_range(0, body.size() - 2)];
            end
        end
        foreach (body[i]) push_byte(body[i], i == body.size() - 1);
        msgs_sent++;
    endtask

    function automatic t_msg_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return MSG_FULL;
        if (r < 35) return MSG_TRAILING;
        if (r < 40) return MSG_RELAY_ABSENT;
        if (r < 65) return MSG_CUT;
        if (r < 80) return MSG_TOO_LONG;
        if (r < 83) return MSG_TOO_LONG_AT_MARK;
        return MSG_NOISE;
    endfunction

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_fields.size() != 0)
            @(negedge i_clk);
        // dropped bytes give no results, so allow the pipeline to settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ---------------- byte source ----------------
    int src_gap = 0;
    int src_calm = 0;

    always @(posedge i_clk) begin
        t_body_byte it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
            src_calm <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                it = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.data;
                s_axis_tlast <= it.eom;
                if (src_calm != 0) begin
                    src_calm <= src_calm - 1;
                end else begin
                    src_gap <= draw_gap();
                    if ($urandom_range(0, 39) == 0) src_calm <= $urandom_range(20, 60);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result sink ----------------
    int sink_wait = 0;
    int sink_calm = 0;
    int stall_served = 0;

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
            sink_calm <= 0;
            stall_served <= 0;
        end else if (stall_served != stall_asks) begin
            stall_served <= stall_asks;
            sink_wait <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_calm != 0) begin
            sink_calm <= sink_calm - 1;
            m_axis_tready <= 1'b1;
        end else begin
            gap = draw_gap();
            if ($urandom_range(0, 39) == 0) sink_calm <= $urandom_range(20, 60);
            if (gap == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                sink_wait <= gap - 1;
            end
        end
    end

    // ---------------- predict and compare ----------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cap_model = CAP_RESET;
            p_drop = 1'b0;
            restart_message();
        end else begin
            if (i_cfg_wr_en) cap_model = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.code = m_axis_tuser[4:0];
                got.status = m_axis_tuser[6:5];
                got.value = m_axis_tdata;
                got.last = m_axis_tlast;
                results_seen++;
                if (expected_fields.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none,", $time);
                    $display("%0t:   got code %0d value %h status %0d last %0d",
                             $time, got.code, got.value, got.status, got.last);
                end else begin
                    want = expected_fields.pop_front();
                    if (got != want) begin
                        errors++;
                        $display("%0t: result mismatch, expected code %0d value %h",
                                 $time, want.code, want.value);
                        $display("%0t:   expected status %0d last %0d",
                                 $time, want.status, want.last);
                        $display("%0t:   got code %0d value %h status %0d last %0d",
                                 $time, got.code, got.value, got.status, got.last);
                    end
                end
            end
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        int start_bytes;
        logic [10:0] caps[NUM_PHASES];
        caps[0] = CAP_RESET;
        caps[1] = 11'd0;
        caps[2] = 11'd1;
        caps[3] = 11'd2047;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_idle();
                @(posedge i_clk);
                i_cfg_wr_en <= 1'b1;
                i_cfg_wr_data <= caps[phase];
                @(posedge i_clk);
                i_cfg_wr_en <= 1'b0;
                @(negedge i_clk);
            end
            phase_cap = caps[phase];
            start_bytes = body_bytes;
            case (phase)
                0: begin
                    // short bodies: cut at once, cut at or just after version, byte extremes
                    push_byte(8'h00, 1'b1);
                    repeat (3) push_byte(8'hff, 1'b0);
                    push_byte(8'hff, 1'b1);
                    push_byte(8'h71, 1'b0);
                    push_byte(8'h11, 1'b0);
                    push_byte(8'h01, 1'b0);
                    push_byte(8'h00, 1'b0);
                    push_byte(8'h80, 1'b1);
                    repeat (3) push_byte(8'h00, 1'b0);
                    push_byte(8'h80, 1'b1);
                    push_byte(8'h55, 1'b0);
                    push_byte(8'haa, 1'b1);
                    msgs_sent += 5;
                    queue_message(MSG_RELAY_ABSENT);
                end
                1: queue_message(MSG_TOO_LONG_AT_MARK);
                2: queue_message(MSG_TRAILING);
                3: queue_message(MSG_TOO_LONG);
                default: queue_message(MSG_FULL);
            endcase
            // back-pressure long enough to fill the result queue and stall the input
            if (phase == 1 || phase == 3) stall_asks++;
            while (body_bytes - start_bytes < PHASE_BYTES) queue_message(pick_kind());
        end

        wait_idle();
        $display("Run covered %0d messages (%0d body bytes) and checked %0d results",
                 msgs_sent, body_bytes, results_seen);
        $display("over %0d agent capacity settings, including 0, 1 and 2047", NUM_PHASES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
